>>> rtl/core/tea_block_cipher_with_tail_xor_defines.svh
// Assertion macros for the TEA block cipher core.
`ifndef TEA_BLOCK_CIPHER_WITH_TAIL_XOR_DEFINES_SVH
`define TEA_BLOCK_CIPHER_WITH_TAIL_XOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TEABC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TEABC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TEABC_ASSERT(lbl, clk, rstn, prop, msg)
`define TEABC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/teabc_pkg.sv
// Shared types, constants and the TEA mixing function.
`default_nettype none
package teabc_pkg;
    localparam int          ROUND_COUNT_DEF = 32;
    localparam logic [31:0] TEA_DELTA       = 32'h9e3779b9;
    localparam logic [7:0]  TAIL_MASK       = 8'h9e;
    localparam int          CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_FIRST  = 2'd0,
        CFG_KEY_SECOND = 2'd1,
        CFG_DECRYPT    = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic        valid;
        logic        full;
        logic        decrypt;
        logic [31:0] y;
        logic [31:0] z;
    } t_stage;

    function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
                                            input logic [31:0] a, input logic [31:0] b);
        tea_mix = ((v << 4) + a) ^ (v + sum) ^ ((v >> 5) + b);
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/teabc_cell.sv
// One half round of TEA: updates one word of a full block and hands the block on.
`default_nettype none
module teabc_cell #(
    parameter int ROUNDS = teabc_pkg::ROUND_COUNT_DEF,
    parameter int IDX    = 0,
    parameter int HALF   = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [31:0]      i_key_a,
    input  wire logic [31:0]      i_key_b,
    input  wire teabc_pkg::t_stage i_stage,
    output teabc_pkg::t_stage     o_stage
);
    localparam logic [31:0] SUM_ENC = 32'(64'(teabc_pkg::TEA_DELTA) * 64'(IDX + 1));
    localparam logic [31:0] SUM_DEC = 32'(64'(teabc_pkg::TEA_DELTA) * 64'(ROUNDS - IDX));
    localparam logic        IS_HALF1 = (HALF == 1);

    teabc_pkg::t_stage n_stage;
    teabc_pkg::t_stage r_stage;
    logic              r_valid;
    logic              upd_y;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [31:0]       sum;
    logic [31:0]       mix;
    logic [31:0]       res;

    always_comb begin
        n_stage = i_stage;
        upd_y   = i_stage.decrypt ? IS_HALF1 : !IS_HALF1;
        src     = upd_y ? i_stage.z : i_stage.y;
        dst     = upd_y ? i_stage.y : i_stage.z;
        sum     = i_stage.decrypt ? SUM_DEC : SUM_ENC;
        mix     = teabc_pkg::tea_mix(src, sum, i_key_a, i_key_b);
        res     = i_stage.decrypt ? (dst - mix) : (dst + mix);
        if (i_stage.full) begin
            if (upd_y) begin
                n_stage.y = res;
            end else begin
                n_stage.z = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    always_comb begin
        o_stage       = r_stage;
        o_stage.valid = r_valid;
    end
endmodule
`default_nettype wire

>>> rtl/core/tea_block_cipher_with_tail_xor.sv
// TEA block cipher with tail XOR: entry stage, chain of half-round cells, output.
// One word enters per cycle unless the chain is held. It passes through an entry
// register followed by a chain of 2*ROUND_COUNT half-round cells, the last of which is
// the output register. The whole chain advances together and holds while a result
// waits on the output. Full blocks (byte count 8 or more) are encrypted or decrypted
// per the mode register with the key (a,b,a,b); shorter blocks get each valid byte
// XORed with 0x9e and the rest zeroed. Mode is sampled as words enter and the key is
// read by every cell, so write them only while idle.
`default_nettype none
`include "tea_block_cipher_with_tail_xor_defines.svh"
module tea_block_cipher_with_tail_xor #(
    parameter int ROUND_COUNT = teabc_pkg::ROUND_COUNT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [teabc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [31:0]                     i_data_low_word,
    input  wire logic [31:0]                     i_data_high_word,
    input  wire logic [3:0]                      i_byte_count,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [31:0]                          o_result_low_word,
    output logic [31:0]                          o_result_high_word
);
    localparam int CELLS = 2 * ROUND_COUNT;

    logic [31:0]       r_key_first;
    logic [31:0]       r_key_second;
    logic              r_decrypt;
    logic              en;
    teabc_pkg::t_stage n_in;
    teabc_pkg::t_stage r_in;
    logic              r_in_valid;
    teabc_pkg::t_stage w_stage [0:CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_first  <= '0;
            r_key_second <= '0;
            r_decrypt    <= 1'b0;
        end else if (i_cfg_we) begin
            case (teabc_pkg::t_cfg_index'(i_cfg_index))
                teabc_pkg::CFG_KEY_FIRST:  r_key_first  <= i_cfg_data;
                teabc_pkg::CFG_KEY_SECOND: r_key_second <= i_cfg_data;
                teabc_pkg::CFG_DECRYPT:    r_decrypt    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_comb begin
        n_in         = '0;
        n_in.valid   = i_in_valid;
        n_in.full    = i_byte_count[3];
        n_in.decrypt = r_decrypt;
        if (i_byte_count[3]) begin
            n_in.y = i_data_low_word;
            n_in.z = i_data_high_word;
        end else begin
            for (int i = 0; i < 4; i++) begin
                if (4'(i) < i_byte_count) begin
                    n_in.y[8*i +: 8] = i_data_low_word[8*i +: 8] ^ teabc_pkg::TAIL_MASK;
                end
                if (4'(i + 4) < i_byte_count) begin
                    n_in.z[8*i +: 8] = i_data_high_word[8*i +: 8] ^ teabc_pkg::TAIL_MASK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= n_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= n_in;
        end
    end

    always_comb begin
        w_stage[0]       = r_in;
        w_stage[0].valid = r_in_valid;
    end

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        teabc_cell #(
            .ROUNDS (ROUND_COUNT),
            .IDX    (k / 2),
            .HALF   (k % 2)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_key_a (r_key_first),
            .i_key_b (r_key_second),
            .i_stage (w_stage[k]),
            .o_stage (w_stage[k+1])
        );
    end

    assign o_out_valid        = w_stage[CELLS].valid;
    assign o_result_low_word  = w_stage[CELLS].y;
    assign o_result_high_word = w_stage[CELLS].z;

    `TEABC_ASSERT(a_stall_freezes_chain, i_clk, i_rst_n, !en |=> $stable(w_stage[CELLS]), "chain moved while stalled")
    `TEABC_ASSERT_ALWAYS(a_reset_empties_output, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `TEABC_ASSERT(a_tail_passes_cell, i_clk, i_rst_n, en && w_stage[0].valid && !w_stage[0].full |=> (w_stage[1].y == $past(w_stage[0].y)) && (w_stage[1].z == $past(w_stage[0].z)), "tail word altered by cell")
endmodule
`default_nettype wire

>>> tb/tea_cipher_checker.sv
// Checker for the TEA cipher block: tracks key and mode writes, predicts each block, compares.
module tea_cipher_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [teabc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [31:0]                     i_data_low_word,
    input  logic [31:0]                     i_data_high_word,
    input  logic [3:0]                      i_byte_count,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [31:0]                     i_result_low_word,
    input  logic [31:0]                     i_result_high_word,
    output int                              o_fail_count,
    output int                              o_pending
);
    localparam logic [31:0] GOLDEN     = 32'h9e3779b9;
    localparam int          TEA_ROUNDS = 32;
    localparam logic [7:0]  TAIL_BYTE  = 8'h9e;
    localparam int          PRINT_CAP  = 20;

    typedef struct packed {
        logic [31:0] low;
        logic [31:0] high;
    } t_block;

    logic [31:0] key_a;
    logic [31:0] key_b;
    logic        decrypting;
    t_block      expected_blocks[$];
    int          mismatches;

    function automatic t_block predict_block(input logic [31:0] lo, input logic [31:0] hi,
                                             input logic [3:0] count);
        t_block      res;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        logic [63:0] raw;
        y   = lo;
        z   = hi;
        raw = {hi, lo};
        if (count >= 4'd8) begin
            if (decrypting) begin
                sum = GOLDEN * TEA_ROUNDS;
                for (int r = 0; r < TEA_ROUNDS; r++) begin
                    z   = z - (((y << 4) + key_a) ^ (y + sum) ^ ((y >> 5) + key_b));
                    y   = y - (((z << 4) + key_a) ^ (z + sum) ^ ((z >> 5) + key_b));
                    sum = sum - GOLDEN;
                end
            end else begin
                sum = 32'd0;
                for (int r = 0; r < TEA_ROUNDS; r++) begin
                    sum = sum + GOLDEN;
                    y   = y + (((z << 4) + key_a) ^ (z + sum) ^ ((z >> 5) + key_b));
                    z   = z + (((y << 4) + key_a) ^ (y + sum) ^ ((y >> 5) + key_b));
                end
            end
            res.low  = y;
            res.high = z;
        end else begin
            // tail block: valid bytes masked, the rest cleared
            for (int i = 0; i < 8; i++) begin
                if (i < count) begin
                    raw[8*i +: 8] = raw[8*i +: 8] ^ TAIL_BYTE;
                end else begin
                    raw[8*i +: 8] = 8'h00;
                end
            end
            res.low  = raw[31:0];
            res.high = raw[63:32];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("[%0t] tea check: %s got %08h want %08h", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_block want;
        if (!i_rst_n) begin
            expected_blocks.delete();
            key_a      = 32'd0;
            key_b      = 32'd0;
            decrypting = 1'b0;
            mismatches = 0;
        end else begin
            // predict with the settings in force as the word enters
            if (i_in_valid && i_in_ready) begin
                expected_blocks.push_back(predict_block(i_data_low_word, i_data_high_word,
                                                        i_byte_count));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("word with nothing pending, low", i_result_low_word, 32'd0);
                end else begin
                    want = expected_blocks.pop_front();
                    if (i_result_low_word !== want.low) begin
                        report_mismatch("result_low_word", i_result_low_word, want.low);
                    end
                    if (i_result_high_word !== want.high) begin
                        report_mismatch("result_high_word", i_result_high_word, want.high);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    teabc_pkg::CFG_KEY_FIRST:  key_a      = i_cfg_data;
                    teabc_pkg::CFG_KEY_SECOND: key_b      = i_cfg_data;
                    teabc_pkg::CFG_DECRYPT:    decrypting = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_blocks.size();
    end
endmodule

>>> tb/tb.sv
// Testbench top for the TEA cipher block: clock, reset, stimulus, backpressure and verdict.
module tb;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 200;
    localparam int DRAIN_CYCLES    = 80;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 133;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    teabc_pkg::t_cfg_index cfg_index = teabc_pkg::CFG_KEY_FIRST;
    logic [31:0]           cfg_data = 32'd0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [31:0]           data_low = 32'd0;
    logic [31:0]           data_high = 32'd0;
    logic [3:0]            byte_count = 4'd8;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [31:0]           result_low;
    logic [31:0]           result_high;
    int                    fail_count;
    int                    pending;

    bit                    quiet = 1'b0;
    bit                    hold_req = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tea_block_cipher_with_tail_xor uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_data_low_word    (data_low),
        .i_data_high_word   (data_high),
        .i_byte_count       (byte_count),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_result_low_word  (result_low),
        .o_result_high_word (result_high)
    );

    tea_cipher_checker checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_data_low_word    (data_low),
        .i_data_high_word   (data_high),
        .i_byte_count       (byte_count),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_result_low_word  (result_low),
        .i_result_high_word (result_high),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 32'd0;
        end else if (r == 1) begin
            return 32'hffffffff;
        end
        return $urandom;
    endfunction

    function automatic logic [3:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 4'd8;
        end else if (r < 80) begin
            return 4'($urandom_range(1, 7));
        end else if (r < 93) begin
            return 4'($urandom_range(9, 15));
        end
        return 4'd0;
    endfunction

    // called at a clock edge; returns at the edge where the word is taken
    task automatic send_word(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [3:0] count);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_low   <= lo;
        data_high  <= hi;
        byte_count <= count;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input teabc_pkg::t_cfg_index idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] key_lo, input logic [31:0] key_hi,
                                 input logic mode);
        logic [31:0] mode_data;
        mode_data    = $urandom_range(0, 1) ? $urandom : 32'd0;
        mode_data[0] = mode;
        write_reg(teabc_pkg::CFG_KEY_FIRST, key_lo);
        write_reg(teabc_pkg::CFG_KEY_SECOND, key_hi);
        write_reg(teabc_pkg::CFG_DECRYPT, mode_data);
        if ($urandom_range(0, 2) == 0) begin
            write_reg(teabc_pkg::CFG_UNUSED, $urandom);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : receiver
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tea_block_cipher_with_tail_xor verification failed");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key (all zero), encrypt
        send_word(32'd0, 32'd0, 4'd8);
        send_word(32'hffffffff, 32'hffffffff, 4'd8);
        for (int n = 0; n < 16; n++) begin
            send_word(32'h76543210, 32'hfedcba98, n[3:0]);
        end
        wait_for_results();

        // all-ones key, decrypt
        load_settings(32'hffffffff, 32'hffffffff, 1'b1);
        send_word(32'd0, 32'd0, 4'd8);
        send_word(32'hffffffff, 32'hffffffff, 4'd8);
        send_word(32'h01234567, 32'h89abcdef, 4'd15);
        send_word(32'hffffffff, 32'hffffffff, 4'd7);
        wait_for_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_settings(pick_word(), pick_word(), p[0]);
            quiet = (p % 4 == 1);
            if (p == 2) begin
                // back the output up long enough to fill the pipe and stall the input
                quiet    = 1'b1;
                hold_req = 1'b1;
            end
            repeat (WORDS_PER_PHASE) send_word(pick_word(), pick_word(), pick_count());
            wait_for_results();
        end
        quiet = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tea_block_cipher_with_tail_xor verification clean");
        end else begin
            $display("tea_block_cipher_with_tail_xor verification failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/teabc_pkg.sv
rtl/core/teabc_cell.sv
rtl/core/tea_block_cipher_with_tail_xor.sv
tb/tea_cipher_checker.sv
tb/tb.sv
